FILE: rtl/nec_pkg.sv
package nec_pkg;

    localparam int ROW_W         = 64;
    localparam int IDX_W         = 6;
    localparam int CNT_W         = 7;
    localparam int COL_W         = 8;
    localparam int MAX_NODES_DEF = 64;

    localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;
    localparam logic [COL_W-1:0] COL_EPSILON = 8'd0;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } t_mem_ctl;

endpackage

FILE: rtl/nec_row_mem.sv
module nec_row_mem #(
    parameter int DEPTH = nec_pkg::MAX_NODES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nec_pkg::t_mem_ctl             i_ctl,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [nec_pkg::ROW_W-1:0]     i_wr_data,
    output logic [nec_pkg::ROW_W-1:0]     o_rd_data
);
    import nec_pkg::*;

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_row_vld;
    logic [ROW_W-1:0] r_rd_data;
    logic             r_rd_hit;

    // rows not written since the last clear read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_ctl.clear) begin
            r_row_vld <= '0;
        end else if (i_ctl.wr_en) begin
            r_row_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_hit  <= r_row_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

FILE: rtl/nfa_epsilon_closure.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+--------------------------------------------
// in       | input     | i_in_valid / o_in_stall | source_state, target_state, symbol_column,
//          |           |                         | has_edge, is_last
// out      | output    | o_out_valid/i_out_stall | state_index, closure_mask, last_result
// cfg      | input     | i_cfg_wr_en             | i_cfg_wr_data (state_count)
//
// Edge requests load at one per cycle; each is a read-modify-write of one matrix row
// with forwarding from the previous write.
// After a last request: a flush state, then per state in use a walk over the reached states
// in use and an emit state, which waits while the output is stalled.
// Input stalls from the last request until the final result; the matrix clears with it.
// Reset is synchronous, active low; state_count resets to 64.
module nfa_epsilon_closure #(
    parameter int MAX_NODES = nec_pkg::MAX_NODES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [nec_pkg::CNT_W-1:0]     i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [nec_pkg::IDX_W-1:0]     i_source_state,
    input  logic [nec_pkg::IDX_W-1:0]     i_target_state,
    input  logic [nec_pkg::COL_W-1:0]     i_symbol_column,
    input  logic                          i_has_edge,
    input  logic                          i_is_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [nec_pkg::IDX_W-1:0]     o_state_index,
    output logic [nec_pkg::ROW_W-1:0]     o_closure_mask,
    output logic                          o_last_result
);
    import nec_pkg::*;

    localparam int AW = $clog2(MAX_NODES);

    typedef enum logic [1:0] {
        S_LOAD,
        S_FLUSH,
        S_WALK,
        S_EMIT
    } t_state;

    function automatic logic [IDX_W-1:0] low_index(input logic [ROW_W-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    t_state           r_state;
    logic [CNT_W-1:0] r_cfg_count;
    logic [CNT_W-1:0] r_count;

    logic             r_ld_valid;
    logic [AW-1:0]    r_ld_addr;
    logic [IDX_W-1:0] r_ld_tgt;
    logic             r_fw_valid;
    logic [AW-1:0]    r_fw_addr;
    logic [ROW_W-1:0] r_fw_data;

    logic [AW-1:0]    r_s;
    logic [ROW_W-1:0] r_reach;
    logic [ROW_W-1:0] r_expanded;
    logic [ROW_W-1:0] r_act_mask;
    logic             r_inflight;

    logic             r_o_valid;
    logic [IDX_W-1:0] r_o_idx;
    logic [ROW_W-1:0] r_o_mask;
    logic             r_o_last;

    logic             in_acc;
    logic             edge_ok;
    logic [CNT_W-1:0] n_count;
    logic [ROW_W-1:0] n_act_mask;
    logic [ROW_W-1:0] pend;
    logic [IDX_W-1:0] pick;
    logic             walk_issue;
    logic [ROW_W-1:0] reach_merged;
    logic [ROW_W-1:0] ld_base;
    logic [ROW_W-1:0] ld_wdata;
    logic             out_free;
    logic             s_last;
    t_mem_ctl         mem_ctl;
    logic [AW-1:0]    mem_rd_addr;
    logic [ROW_W-1:0] rd_data;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign edge_ok = i_has_edge && (i_symbol_column == COL_EPSILON)
                     && ({1'b0, i_source_state} < CNT_W'(MAX_NODES))
                     && ({1'b0, i_target_state} < CNT_W'(MAX_NODES));

    always_comb begin
        if (r_cfg_count == '0) begin
            n_count = CNT_W'(1);
        end else if (r_cfg_count > CNT_W'(MAX_NODES)) begin
            n_count = CNT_W'(MAX_NODES);
        end else begin
            n_count = r_cfg_count;
        end
    end

    always_comb begin
        for (int i = 0; i < ROW_W; i++) begin
            n_act_mask[i] = CNT_W'(i) < r_count;
        end
    end

    assign pend         = r_reach & r_act_mask & ~r_expanded;
    assign pick         = low_index(pend);
    assign walk_issue   = (r_state == S_WALK) && (pend != '0);
    assign reach_merged = r_reach | (r_inflight ? rd_data : '0);

    assign ld_base  = (r_fw_valid && (r_fw_addr == r_ld_addr)) ? r_fw_data : rd_data;
    assign ld_wdata = ld_base | (ROW_W'(1) << r_ld_tgt);

    assign out_free = !r_o_valid || !i_out_stall;
    assign s_last   = (CNT_W'(r_s) + CNT_W'(1)) == r_count;

    assign mem_ctl.rd_en = (in_acc && edge_ok) || walk_issue;
    assign mem_ctl.wr_en = r_ld_valid;
    assign mem_ctl.clear = (r_state == S_EMIT) && out_free && s_last;
    assign mem_rd_addr   = (r_state == S_WALK) ? pick[AW-1:0] : i_source_state[AW-1:0];

    nec_row_mem #(
        .DEPTH (MAX_NODES)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_rd_addr (mem_rd_addr),
        .i_wr_addr (r_ld_addr),
        .i_wr_data (ld_wdata),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cfg_count <= COUNT_RESET;
            r_ld_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_inflight  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg_count <= i_cfg_wr_data;
            end

            r_ld_valid <= in_acc && edge_ok;
            r_ld_addr  <= i_source_state[AW-1:0];
            r_ld_tgt   <= i_target_state;
            r_fw_valid <= r_ld_valid;
            r_fw_addr  <= r_ld_addr;
            r_fw_data  <= ld_wdata;

            if ((r_state == S_EMIT) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (in_acc && i_is_last) begin
                        r_count <= n_count;
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    r_act_mask <= n_act_mask;
                    r_s        <= '0;
                    r_reach    <= ROW_W'(1);
                    r_expanded <= '0;
                    r_inflight <= 1'b0;
                    r_state    <= S_WALK;
                end
                S_WALK: begin
                    r_reach    <= reach_merged;
                    r_inflight <= walk_issue;
                    if (walk_issue) begin
                        r_expanded[pick] <= 1'b1;
                    end
                    if (!walk_issue && !r_inflight) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_idx    <= IDX_W'(r_s);
                        r_o_mask   <= r_reach;
                        r_o_last   <= s_last;
                        r_reach    <= ROW_W'(1) << (r_s + AW'(1));
                        r_expanded <= '0;
                        r_s        <= r_s + AW'(1);
                        r_state    <= s_last ? S_LOAD : S_WALK;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_LOAD);
    assign o_out_valid    = r_o_valid;
    assign o_state_index  = r_o_idx;
    assign o_closure_mask = r_o_mask;
    assign o_last_result  = r_o_last;

    a_self_in_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> r_reach[r_s])
        else $error("walk lost the start state of its closure");

    a_expanded_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_expanded & ~r_reach) == '0))
        else $error("row expanded for a state outside the reach set");

    a_expanded_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_expanded & ~r_act_mask) == '0))
        else $error("row of an unused state followed");

    a_load_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ld_valid |-> (r_state == S_LOAD || r_state == S_FLUSH))
        else $error("matrix write during closure walk");

endmodule

FILE: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nec_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [ROW_W-1:0] mask;
        logic             done;
    } t_closure;

    class closure_scoreboard;
        logic [ROW_W-1:0] eps_rows [MAX_NODES_DEF];
        logic [CNT_W-1:0] count_reg;
        t_closure         pending_closures [$];
        int               errors;

        function new();
            foreach (eps_rows[r]) eps_rows[r] = '0;
            count_reg = COUNT_RESET;
            errors    = 0;
        endfunction

        function void set_count(logic [CNT_W-1:0] v);
            count_reg = v;
        endfunction

        // zero acts as one, anything above the matrix size acts as the full size
        function int active_states();
            if (count_reg == 0) return 1;
            if (count_reg > MAX_NODES_DEF) return MAX_NODES_DEF;
            return int'(count_reg);
        endfunction

        // rows of states outside the active range are never followed
        function logic [ROW_W-1:0] reach_from(int s, int n);
            logic [ROW_W-1:0] reach;
            logic [ROW_W-1:0] prev;
            reach = {{(ROW_W-1){1'b0}}, 1'b1} << s;
            prev  = '0;
            while (reach != prev) begin
                prev = reach;
                for (int i = 0; i < n; i++) begin
                    if (prev[i]) reach |= eps_rows[i];
                end
            end
            return reach;
        endfunction

        function void note_request(logic [IDX_W-1:0] src, logic [IDX_W-1:0] tgt,
                                   logic [COL_W-1:0] col, logic has_e, logic last_f);
            int       n;
            t_closure c;
            if (has_e && col == COL_EPSILON) eps_rows[src][tgt] = 1'b1;
            if (last_f) begin
                n = active_states();
                for (int s = 0; s < n; s++) begin
                    c.index = IDX_W'(s);
                    c.mask  = reach_from(s, n);
                    c.done  = (s == n - 1);
                    pending_closures.push_back(c);
                end
                foreach (eps_rows[r]) eps_rows[r] = '0;
            end
        endfunction

        function void check_result(logic [IDX_W-1:0] idx, logic [ROW_W-1:0] mask,
                                   logic done);
            t_closure want;
            if (pending_closures.size() == 0) begin
                $display("%0t: unexpected result: state %0d mask %h last %b",
                         $time, idx, mask, done);
                errors++;
                return;
            end
            want = pending_closures.pop_front();
            if (idx !== want.index) begin
                $display("%0t: state_index expected %0d actual %0d",
                         $time, want.index, idx);
                errors++;
            end
            if (mask !== want.mask) begin
                $display("%0t: closure_mask (state %0d) expected %h actual %h",
                         $time, want.index, want.mask, mask);
                errors++;
            end
            if (done !== want.done) begin
                $display("%0t: last_result (state %0d) expected %b actual %b",
                         $time, want.index, want.done, done);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_cfg_wr_en     = 1'b0;
    logic [CNT_W-1:0] i_cfg_wr_data   = '0;
    logic             i_in_valid      = 1'b0;
    logic             o_in_stall;
    logic [IDX_W-1:0] i_source_state  = '0;
    logic [IDX_W-1:0] i_target_state  = '0;
    logic [COL_W-1:0] i_symbol_column = '0;
    logic             i_has_edge      = 1'b0;
    logic             i_is_last       = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall     = 1'b0;
    logic [IDX_W-1:0] o_state_index;
    logic [ROW_W-1:0] o_closure_mask;
    logic             o_last_result;

    closure_scoreboard closure_sb = new();

    bit steady    = 1'b0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int sent_reqs = 0;

    nfa_epsilon_closure dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_source_state  (i_source_state),
        .i_target_state  (i_target_state),
        .i_symbol_column (i_symbol_column),
        .i_has_edge      (i_has_edge),
        .i_is_last       (i_is_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_state_index   (o_state_index),
        .o_closure_mask  (o_closure_mask),
        .o_last_result   (o_last_result)
    );

    always #6 i_clk = ~i_clk;

    // output backpressure; a long hold is started when the stimulus asks for one
    always @(negedge i_clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !steady && ($urandom_range(0, 99) < 20);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            closure_sb.check_result(o_state_index, o_closure_mask, o_last_result);
    end

    task automatic write_count(input logic [CNT_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        closure_sb.set_count(v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_req(input logic [IDX_W-1:0] src, input logic [IDX_W-1:0] tgt,
                            input logic [COL_W-1:0] col, input logic has_e,
                            input logic last_f);
        while (!steady && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_source_state  <= src;
        i_target_state  <= tgt;
        i_symbol_column <= col;
        i_has_edge      <= has_e;
        i_is_last       <= last_f;
        do @(posedge i_clk); while (o_in_stall);
        closure_sb.note_request(src, tgt, col, has_e, last_f);
        sent_reqs++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (closure_sb.pending_closures.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // one transition set: edges mostly among the active states, ending in a last request
    task automatic send_graph(input int n_edges, input int span);
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] tgt;
        logic [COL_W-1:0] col;
        logic             has_e;
        for (int k = 0; k <= n_edges; k++) begin
            src   = ($urandom_range(0, 99) < 85) ? IDX_W'($urandom_range(0, span - 1))
                                                 : IDX_W'($urandom);
            tgt   = ($urandom_range(0, 99) < 85) ? IDX_W'($urandom_range(0, span - 1))
                                                 : IDX_W'($urandom);
            col   = ($urandom_range(0, 99) < 80) ? COL_EPSILON
                                                 : COL_W'($urandom_range(1, 255));
            has_e = ($urandom_range(0, 99) < 90);
            if (k == n_edges && $urandom_range(0, 3) == 0) has_e = 1'b0;
            send_req(src, tgt, col, has_e, k == n_edges);
        end
    endtask

    initial begin
        int               phase;
        int               span;
        int               n_graphs;
        logic [CNT_W-1:0] cnt;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset count of 64: cross edges at the extremes, ignored column, bare markers
        send_req(6'd0, 6'd63, COL_EPSILON, 1'b1, 1'b0);
        send_req(6'd63, 6'd0, COL_EPSILON, 1'b1, 1'b0);
        send_req(6'd5, 6'd6, 8'hFF, 1'b1, 1'b0);
        send_req(6'd0, 6'd0, COL_EPSILON, 1'b0, 1'b0);
        send_req(6'd0, 6'd0, COL_EPSILON, 1'b0, 1'b1);
        wait_idle();

        // count 0 acts as 1; row 63 is unused but still a target
        write_count(7'd0);
        send_req(6'd0, 6'd0, COL_EPSILON, 1'b1, 1'b0);
        send_req(6'd0, 6'd63, COL_EPSILON, 1'b1, 1'b0);
        send_req(6'd63, 6'd0, COL_EPSILON, 1'b1, 1'b1);
        wait_idle();

        // count above the limit; chain plus a last request on a non-epsilon column
        write_count(7'd127);
        send_req(6'd0, 6'd1, COL_EPSILON, 1'b1, 1'b0);
        send_req(6'd1, 6'd2, COL_EPSILON, 1'b1, 1'b0);
        send_req(6'd2, 6'd3, COL_EPSILON, 1'b1, 1'b0);
        send_req(6'h2A, 6'h15, COL_EPSILON, 1'b1, 1'b0);
        send_req(6'd3, 6'd0, 8'h01, 1'b1, 1'b1);
        wait_idle();

        write_count(7'd1);
        send_req(6'h15, 6'h2A, 8'h80, 1'b0, 1'b1);
        wait_idle();

        write_count(7'd64);
        send_req(6'd62, 6'd63, COL_EPSILON, 1'b1, 1'b0);
        send_req(6'd63, 6'd62, COL_EPSILON, 1'b1, 1'b0);
        send_req(6'd62, 6'd63, COL_EPSILON, 1'b1, 1'b0);
        send_req(6'd62, 6'd62, COL_EPSILON, 1'b1, 1'b1);
        wait_idle();

        phase = 0;
        while (sent_reqs < 350) begin
            case ($urandom_range(0, 19))
                0:       cnt = 7'd0;
                1:       cnt = 7'd1;
                2:       cnt = 7'd64;
                3:       cnt = 7'd127;
                4:       cnt = CNT_W'($urandom_range(65, 126));
                5:       cnt = CNT_W'($urandom_range(13, 63));
                default: cnt = CNT_W'($urandom_range(2, 12));
            endcase
            if (phase == 2) cnt = 7'd6;
            if (phase == 2 || $urandom_range(0, 3) != 0) write_count(cnt);
            span     = closure_sb.active_states();
            steady   = (phase == 4);
            n_graphs = (phase == 2) ? 6 : $urandom_range(1, 3);
            if (phase == 2) hold_asks++;
            for (int g = 0; g < n_graphs; g++)
                send_graph($urandom_range(0, (span <= 12) ? 10 : 20), span);
            wait_idle();
            steady = 1'b0;
            phase++;
        end

        repeat (20) @(negedge i_clk);
        if (closure_sb.errors == 0 && closure_sb.pending_closures.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/nec_pkg.sv
rtl/nec_row_mem.sv
rtl/nfa_epsilon_closure.sv
verif/tb_top.sv
